/* design/plfm_pkg.sv */
// ----------------------------------------------------------------------------
// plfm_pkg
// Types and constants shared by the price level matcher modules.
// ----------------------------------------------------------------------------
package plfm_pkg;

    localparam int ID_W    = 63;
    localparam int W32     = 32;
    localparam int VOL_W   = 37;
    localparam int LVL_W   = 38;
    localparam int CNT_OUT = 6;

    localparam logic [LVL_W-1:0] LEVEL_MAX = {LVL_W{1'b1}};
    localparam logic [VOL_W-1:0] VOL_MAX   = {VOL_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_MATCH  = 2'd2,
        CMD_REDUCE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_PUT_OK   = 3'd0,
        KIND_PUT_REJ  = 3'd1,
        KIND_REMOVED  = 3'd2,
        KIND_REM_NF   = 3'd3,
        KIND_TRADE    = 3'd4,
        KIND_SUMMARY  = 3'd5,
        KIND_REDUCED  = 3'd6
    } kind_t;

    typedef struct packed {
        cmd_t              command;
        logic [ID_W-1:0]   order_id;
        logic [W32-1:0]    owner_id;
        logic [W32-1:0]    order_size;
        logic [W32-1:0]    already_filled;
        logic              is_ask;
        logic [W32-1:0]    maker_reserve_price;
        logic [VOL_W-1:0]  volume;
        logic [W32-1:0]    taker_reserve_price;
    } req_t;

    typedef struct packed {
        kind_t              kind;
        logic [ID_W-1:0]    order_id_res;
        logic [VOL_W-1:0]   trade_volume;
        logic               full_match;
        logic               taker_completed;
        logic [W32-1:0]     bidder_hold_price;
        logic [VOL_W-1:0]   open_volume;
        logic [CNT_OUT-1:0] order_count;
        logic               last;
    } res_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [W32-1:0]  owner;
        logic [W32-1:0]  size;
        logic [W32-1:0]  filled;
        logic            side;
        logic [W32-1:0]  price;
    } entry_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN_INIT,
        OP_SCAN_NEXT,
        OP_PUT_WR,
        OP_REM_INIT,
        OP_REM_NEXT,
        OP_REM_UNLINK,
        OP_M1_INIT,
        OP_M1_STEP,
        OP_M2_INIT,
        OP_M2_STEP,
        OP_REDUCE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   emit;
        kind_t  kind;
        logic   last;
    } ctl_t;

    typedef struct packed {
        cmd_t cmd;
        logic put_bad;
        logic scan_last;
        logic dup_hit;
        logic rem_more;
        logic match_more;
        logic hit;
        logic owner_ok;
    } sts_t;

    function automatic logic [VOL_W-1:0] cap_vol(input logic [LVL_W-1:0] v);
        cap_vol = (v > LVL_W'(VOL_MAX)) ? VOL_MAX : v[VOL_W-1:0];
    endfunction

endpackage

/* design/plfm_ctrl.sv */
// ----------------------------------------------------------------------------
// plfm_ctrl
// Sequencer for put scans, remove walks, the two match passes and reduces.
// ----------------------------------------------------------------------------
module plfm_ctrl
    import plfm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  sts_t sts,
    output ctl_t ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_SCAN_RD,
        S_SCAN_EV,
        S_REM_RD,
        S_REM_EV,
        S_M1_RD,
        S_M1_EV,
        S_M2_RD,
        S_M2_EV,
        S_RESP
    } state_t;

    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= KIND_PUT_OK;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        ctl.op     = OP_NONE;
        ctl.emit   = 1'b0;
        ctl.kind   = kind_reg;
        ctl.last   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.op     = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (sts.cmd)
                    CMD_PUT:
                    begin
                        if (sts.put_bad)
                        begin
                            ctl.emit   = 1'b1;
                            ctl.kind   = KIND_PUT_REJ;
                            ctl.last   = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            ctl.op     = OP_SCAN_INIT;
                            state_next = S_SCAN_RD;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        ctl.op     = OP_REM_INIT;
                        state_next = S_REM_RD;
                    end
                    CMD_MATCH:
                    begin
                        ctl.op     = OP_M1_INIT;
                        state_next = S_M1_RD;
                    end
                    CMD_REDUCE:
                    begin
                        ctl.op     = OP_REDUCE;
                        kind_next  = KIND_REDUCED;
                        state_next = S_RESP;
                    end
                endcase
            end
            S_SCAN_RD:
                state_next = S_SCAN_EV;
            S_SCAN_EV:
            begin
                priority if (sts.dup_hit)
                begin
                    ctl.emit   = 1'b1;
                    ctl.kind   = KIND_PUT_REJ;
                    ctl.last   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (sts.scan_last)
                begin
                    ctl.op     = OP_PUT_WR;
                    kind_next  = KIND_PUT_OK;
                    state_next = S_RESP;
                end
                else
                begin
                    ctl.op     = OP_SCAN_NEXT;
                    state_next = S_SCAN_RD;
                end
            end
            S_REM_RD:
            begin
                if (sts.rem_more)
                begin
                    state_next = S_REM_EV;
                end
                else
                begin
                    ctl.emit   = 1'b1;
                    ctl.kind   = KIND_REM_NF;
                    ctl.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REM_EV:
            begin
                priority if (sts.hit && sts.owner_ok)
                begin
                    ctl.op     = OP_REM_UNLINK;
                    kind_next  = KIND_REMOVED;
                    state_next = S_RESP;
                end
                else if (sts.hit)
                begin
                    ctl.emit   = 1'b1;
                    ctl.kind   = KIND_REM_NF;
                    ctl.last   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.op     = OP_REM_NEXT;
                    state_next = S_REM_RD;
                end
            end
            S_M1_RD:
            begin
                if (sts.match_more)
                begin
                    state_next = S_M1_EV;
                end
                else
                begin
                    ctl.op     = OP_M2_INIT;
                    state_next = S_M2_RD;
                end
            end
            S_M1_EV:
            begin
                ctl.op     = OP_M1_STEP;
                state_next = S_M1_RD;
            end
            S_M2_RD:
            begin
                if (sts.match_more)
                begin
                    state_next = S_M2_EV;
                end
                else
                begin
                    ctl.emit   = 1'b1;
                    ctl.kind   = KIND_SUMMARY;
                    ctl.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_M2_EV:
            begin
                ctl.op     = OP_M2_STEP;
                ctl.emit   = 1'b1;
                ctl.kind   = KIND_TRADE;
                state_next = S_M2_RD;
            end
            S_RESP:
            begin
                ctl.emit   = 1'b1;
                ctl.kind   = kind_reg;
                ctl.last   = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

/* design/plfm_dpath.sv */
// ----------------------------------------------------------------------------
// plfm_dpath
// Order slots, FIFO links, level totals and the result register.
// ----------------------------------------------------------------------------
module plfm_dpath
    import plfm_pkg::*;
#(
    parameter int MAX_ORDERS = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t request,
    input  ctl_t ctl,
    output sts_t sts,
    output res_t result,
    output logic result_valid
);

    localparam int AW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int CW = $clog2(MAX_ORDERS + 1);

    entry_t          entry_mem [MAX_ORDERS];
    logic [AW-1:0]   link_mem  [MAX_ORDERS];
    entry_t          q;
    logic [AW-1:0]   lq;

    req_t            req_reg;
    logic [MAX_ORDERS-1:0] valid_reg;
    logic [AW-1:0]   head_reg, tail_reg, cur_reg, prev_reg, free_reg;
    logic            prev_ok_reg, free_ok_reg, stop_reg, pass2_reg;
    logic [CW-1:0]   count_reg, fin_cnt_reg, left_reg;
    logic [LVL_W-1:0] level_reg, fin_lv_reg;
    logic [VOL_W-1:0] want_reg, total_reg;
    res_t            res_reg;
    logic            res_valid_reg;

    // Slot read data is registered and lands in the cycle after the address
    always_ff @(posedge clk)
    begin
        q  <= entry_mem[cur_reg];
        lq <= link_mem[cur_reg];
    end

    // Match step, put, remove and reduce arithmetic
    logic [W32-1:0]   open_w;
    logic [VOL_W-1:0] open_v, step_v, want_after;
    logic             step_full;
    logic [LVL_W-1:0] lv_in, lv_after, rem_lv, put_lv, red_lv;
    logic [LVL_W:0]   put_sum;
    logic [VOL_W-1:0] red_done;
    logic [AW-1:0]    put_slot;

    always_comb
    begin
        open_w     = q.size - q.filled;
        open_v     = VOL_W'(open_w);
        step_v     = (want_reg < open_v) ? want_reg : open_v;
        step_full  = (step_v == open_v);
        want_after = want_reg - step_v;
        lv_in      = pass2_reg ? level_reg : fin_lv_reg;
        lv_after   = (LVL_W'(step_v) > lv_in) ? '0 : lv_in - LVL_W'(step_v);
        rem_lv     = (LVL_W'(open_w) > level_reg) ? '0 : level_reg - LVL_W'(open_w);
        put_sum    = (LVL_W+1)'(level_reg)
                   + (LVL_W+1)'(req_reg.order_size - req_reg.already_filled);
        put_lv     = (put_sum > (LVL_W+1)'(LEVEL_MAX)) ? LEVEL_MAX : put_sum[LVL_W-1:0];
        red_done   = (LVL_W'(req_reg.volume) > level_reg) ? level_reg[VOL_W-1:0]
                                                           : req_reg.volume;
        red_lv     = level_reg - LVL_W'(red_done);
        put_slot   = free_ok_reg ? free_reg : cur_reg;
    end

    always_comb
    begin
        sts.cmd        = req_reg.command;
        sts.put_bad    = (count_reg >= CW'(MAX_ORDERS))
                      || (req_reg.already_filled > req_reg.order_size);
        sts.scan_last  = (cur_reg == AW'(MAX_ORDERS - 1));
        sts.dup_hit    = valid_reg[cur_reg] && (q.id == req_reg.order_id);
        sts.rem_more   = (left_reg != '0);
        sts.match_more = (want_reg != '0) && !stop_reg
                      && ((pass2_reg ? count_reg : fin_cnt_reg) != '0);
        sts.hit        = valid_reg[cur_reg] && (q.id == req_reg.order_id);
        sts.owner_ok   = (q.owner == req_reg.owner_id);
    end

    // Slot and link writes
    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_PUT_WR)
        begin
            entry_mem[put_slot] <= '{id: req_reg.order_id, owner: req_reg.owner_id,
                                     size: req_reg.order_size,
                                     filled: req_reg.already_filled,
                                     side: req_reg.is_ask,
                                     price: req_reg.maker_reserve_price};
            if (count_reg != '0)
            begin
                link_mem[tail_reg] <= put_slot;
            end
        end
        if (ctl.op == OP_M2_STEP)
        begin
            entry_mem[cur_reg] <= '{id: q.id, owner: q.owner, size: q.size,
                                    filled: q.filled + step_v[W32-1:0],
                                    side: q.side, price: q.price};
        end
        if (ctl.op == OP_REM_UNLINK && prev_ok_reg)
        begin
            link_mem[prev_reg] <= lq;
        end
    end

    // Level state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            level_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= ctl.emit;
            unique case (ctl.op)
                OP_PUT_WR:
                begin
                    valid_reg[put_slot] <= 1'b1;
                    if (count_reg == '0)
                    begin
                        head_reg <= put_slot;
                    end
                    tail_reg  <= put_slot;
                    count_reg <= count_reg + 1'b1;
                    level_reg <= put_lv;
                end
                OP_REM_UNLINK:
                begin
                    if (!prev_ok_reg)
                    begin
                        head_reg <= lq;
                    end
                    if (prev_ok_reg && cur_reg == tail_reg)
                    begin
                        tail_reg <= prev_reg;
                    end
                    valid_reg[cur_reg] <= 1'b0;
                    count_reg <= count_reg - 1'b1;
                    level_reg <= rem_lv;
                end
                OP_M2_STEP:
                begin
                    level_reg <= lv_after;
                    if (step_full)
                    begin
                        valid_reg[cur_reg] <= 1'b0;
                        head_reg  <= lq;
                        count_reg <= count_reg - 1'b1;
                    end
                end
                OP_REDUCE:
                    level_reg <= red_lv;
                default:
                begin
                end
            endcase
        end
    end

    // Walk registers
    always_ff @(posedge clk)
    begin
        unique case (ctl.op)
            OP_LOAD:
                req_reg <= request;
            OP_SCAN_INIT:
            begin
                cur_reg     <= '0;
                free_ok_reg <= 1'b0;
            end
            OP_SCAN_NEXT:
            begin
                if (!free_ok_reg && !valid_reg[cur_reg])
                begin
                    free_reg    <= cur_reg;
                    free_ok_reg <= 1'b1;
                end
                cur_reg <= cur_reg + 1'b1;
            end
            OP_REM_INIT:
            begin
                cur_reg     <= head_reg;
                prev_ok_reg <= 1'b0;
                left_reg    <= count_reg;
            end
            OP_REM_NEXT:
            begin
                prev_reg    <= cur_reg;
                prev_ok_reg <= 1'b1;
                cur_reg     <= lq;
                left_reg    <= left_reg - 1'b1;
            end
            OP_M1_INIT:
            begin
                cur_reg     <= head_reg;
                want_reg    <= req_reg.volume;
                fin_cnt_reg <= count_reg;
                fin_lv_reg  <= level_reg;
                stop_reg    <= 1'b0;
                pass2_reg   <= 1'b0;
            end
            OP_M1_STEP:
            begin
                want_reg   <= want_after;
                fin_lv_reg <= lv_after;
                if (step_full)
                begin
                    fin_cnt_reg <= fin_cnt_reg - 1'b1;
                    cur_reg     <= lq;
                end
                else
                begin
                    stop_reg <= 1'b1;
                end
            end
            OP_M2_INIT:
            begin
                cur_reg   <= head_reg;
                want_reg  <= req_reg.volume;
                total_reg <= '0;
                stop_reg  <= 1'b0;
                pass2_reg <= 1'b1;
            end
            OP_M2_STEP:
            begin
                want_reg  <= want_after;
                total_reg <= total_reg + step_v;
                if (step_full)
                begin
                    cur_reg <= lq;
                end
                else
                begin
                    stop_reg <= 1'b1;
                end
            end
            OP_REDUCE:
                total_reg <= red_done;
            default:
            begin
            end
        endcase
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            res_reg.kind              <= ctl.kind;
            res_reg.last              <= ctl.last;
            res_reg.order_id_res      <= req_reg.order_id;
            res_reg.trade_volume      <= '0;
            res_reg.full_match        <= 1'b0;
            res_reg.taker_completed   <= 1'b0;
            res_reg.bidder_hold_price <= '0;
            res_reg.open_volume       <= cap_vol(level_reg);
            res_reg.order_count       <= CNT_OUT'(count_reg);
            unique case (ctl.kind)
                KIND_TRADE:
                begin
                    res_reg.order_id_res      <= q.id;
                    res_reg.trade_volume      <= step_v;
                    res_reg.full_match        <= step_full;
                    res_reg.taker_completed   <= (want_after == '0);
                    res_reg.bidder_hold_price <= q.side ? req_reg.taker_reserve_price
                                                        : q.price;
                    res_reg.open_volume       <= cap_vol(fin_lv_reg);
                    res_reg.order_count       <= CNT_OUT'(fin_cnt_reg);
                end
                KIND_SUMMARY:
                begin
                    res_reg.order_id_res    <= '0;
                    res_reg.trade_volume    <= total_reg;
                    res_reg.taker_completed <= (want_reg == '0);
                end
                KIND_REDUCED:
                begin
                    res_reg.order_id_res <= '0;
                    res_reg.trade_volume <= total_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result       = res_reg;
    assign result_valid = res_valid_reg;

endmodule

/* design/price_level_fifo_matcher.sv */
// ----------------------------------------------------------------------------
// price_level_fifo_matcher
// One price level: FIFO of resting orders with put, remove, match, reduce.
// ----------------------------------------------------------------------------
//   channel   ports                    handshake
//   request   start, busy, request     taken when start high and busy low
//   result    result_valid, result     each valid for a single cycle, no backpressure
//
// Put rejects a bad request up front; to store, the id scan reads every slot,
// and a duplicate id ends it early. Remove walks the orders from the head.
// Match walks the queue twice (totals, then trades). Each slot read costs a
// registered memory read.
// Reset clears valid bits, head, tail, count and volume; no clearing pass.
// Results cannot be stalled; the next request is taken as the last one leaves.
module price_level_fifo_matcher
    import plfm_pkg::*;
#(
    parameter int MAX_ORDERS = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output res_t result,
    output logic result_valid
);

    ctl_t ctl;
    sts_t sts;

    plfm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    plfm_dpath #(
        .MAX_ORDERS (MAX_ORDERS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .ctl          (ctl),
        .sts          (sts),
        .result       (result),
        .result_valid (result_valid)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken without going busy");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_valid && result.last))
        else $error("request finished without a last result");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.order_count <= CNT_OUT'(MAX_ORDERS)))
        else $error("order count beyond capacity");
`endif

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Checks the price level matcher: a directed table, then random puts,
// removes, matches and reduces. A behavioral model of the level computes
// the expected results, which are compared as whole results in arrival order.
// ----------------------------------------------------------------------------
module tb_top
    import plfm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 32;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    req_t request = '0;
    res_t result;
    logic result_valid;

    price_level_fifo_matcher #(.MAX_ORDERS(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .request(request), .result(result), .result_valid(result_valid)
    );

    always #6 clk = ~clk;

    // Level model
    entry_t         book [DEPTH];
    logic           held [DEPTH];
    logic [4:0]     link [DEPTH];
    logic [4:0]     head_q, tail_q;
    int             depth_q;
    logic [LVL_W-1:0] level_q;
    res_t           pending_results[$];
    int             errors = 0;

    // Stimulus table; pin marks rows whose result kind is typed in
    typedef struct {
        req_t  req;
        logic  pin;
        kind_t check_kind;
    } row_t;
    row_t plan[$];
    logic [ID_W-1:0] used_ids[$];

    function automatic logic [LVL_W-1:0] level_take(input logic [LVL_W-1:0] v);
        logic [LVL_W-1:0] d;
        d = (v > level_q) ? level_q : v;
        level_q = level_q - d;
        return d;
    endfunction

    function automatic res_t make_res(kind_t k, logic [ID_W-1:0] id,
                                      logic [VOL_W-1:0] vol, logic full,
                                      logic done, logic [W32-1:0] price);
        res_t r;
        r = '0;
        r.kind = k; r.order_id_res = id; r.trade_volume = vol;
        r.full_match = full; r.taker_completed = done; r.bidder_hold_price = price;
        return r;
    endfunction

    task automatic predict_level(input req_t q);
        res_t outs[$];
        int slot, cur, prev, left;
        logic bad, found;
        logic [VOL_W-1:0] want, total, v, open_v;
        logic [W32-1:0] price;
        logic full;
        case (q.command)
            CMD_PUT:
            begin
                bad = (depth_q >= DEPTH) || (q.already_filled > q.order_size);
                slot = -1;
                for (int s = 0; s < DEPTH; s++)
                begin
                    if (held[s] && book[s].id == q.order_id) bad = 1'b1;
                    if (!held[s] && slot < 0) slot = s;
                end
                if (bad || slot < 0)
                    outs.insert(outs.size(),
                                make_res(KIND_PUT_REJ, q.order_id, '0, 1'b0, 1'b0, '0));
                else
                begin
                    book[slot] = '{q.order_id, q.owner_id, q.order_size,
                                   q.already_filled, q.is_ask, q.maker_reserve_price};
                    held[slot] = 1'b1;
                    link[slot] = '0;
                    if (depth_q == 0) head_q = 5'(slot);
                    else link[tail_q] = 5'(slot);
                    tail_q = 5'(slot);
                    depth_q++;
                    v = q.order_size - q.already_filled;
                    level_q = (LVL_W'(v) > LEVEL_MAX - level_q) ? LEVEL_MAX
                            : level_q + LVL_W'(v);
                    outs.insert(outs.size(),
                                make_res(KIND_PUT_OK, q.order_id, '0, 1'b0, 1'b0, '0));
                end
            end
            CMD_REMOVE:
            begin
                cur = head_q; prev = -1; left = depth_q; found = 1'b0;
                while (left > 0)
                begin
                    if (held[cur] && book[cur].id == q.order_id)
                    begin
                        if (book[cur].owner == q.owner_id)
                        begin
                            found = 1'b1;
                            if (prev < 0) head_q = link[cur];
                            else link[prev] = link[cur];
                            if (cur == tail_q && prev >= 0) tail_q = 5'(prev);
                            held[cur] = 1'b0;
                            depth_q--;
                            void'(level_take(LVL_W'(book[cur].size - book[cur].filled)));
                        end
                        break;
                    end
                    prev = cur; cur = link[cur]; left--;
                end
                outs.insert(outs.size(), make_res(found ? KIND_REMOVED : KIND_REM_NF,
                                                  q.order_id, '0, 1'b0, 1'b0, '0));
            end
            CMD_MATCH:
            begin
                want = q.volume; total = '0;
                while (want > 0 && depth_q > 0)
                begin
                    slot = head_q;
                    open_v = book[slot].size - book[slot].filled;
                    v = (want < open_v) ? want : open_v;
                    book[slot].filled += v[W32-1:0];
                    want -= v; total += v;
                    void'(level_take(LVL_W'(v)));
                    full = book[slot].filled == book[slot].size;
                    price = book[slot].side ? q.taker_reserve_price : book[slot].price;
                    outs.insert(outs.size(), make_res(KIND_TRADE, book[slot].id, v, full,
                                                      want == 0, price));
                    if (!full) break;
                    held[slot] = 1'b0;
                    head_q = link[slot];
                    depth_q--;
                end
                outs.insert(outs.size(),
                            make_res(KIND_SUMMARY, '0, total, 1'b0, want == 0, '0));
            end
            default:
            begin
                v = VOL_W'(level_take(LVL_W'(q.volume)));
                outs.insert(outs.size(), make_res(KIND_REDUCED, '0, v, 1'b0, 1'b0, '0));
            end
        endcase
        foreach (outs[k])
        begin
            outs[k].open_volume = cap_vol(level_q);
            outs[k].order_count = CNT_OUT'(depth_q);
            outs[k].last = (k == outs.size() - 1);
            pending_results.insert(pending_results.size(), outs[k]);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result got %p", $time, result);
                errors++;
            end
            else if (result !== pending_results[0])
            begin
                $display("%0t: mismatch expected %p actual %p", $time,
                         pending_results[0], result);
                errors++;
                void'(pending_results.pop_front());
            end
            else
                void'(pending_results.pop_front());
        end
    end

    function automatic req_t blank_req(cmd_t c);
        req_t q;
        q = '0;
        q.command = c;
        q.order_id = ID_W'({$urandom, $urandom});
        q.owner_id = $urandom;
        q.order_size = $urandom;
        q.already_filled = $urandom;
        q.is_ask = 1'($urandom);
        q.maker_reserve_price = $urandom;
        q.volume = VOL_W'({$urandom, $urandom});
        q.taker_reserve_price = $urandom;
        return q;
    endfunction

    function automatic req_t pick_req();
        req_t q;
        int r;
        r = $urandom_range(0, 99);
        q = blank_req(r < 45 ? CMD_PUT : r < 65 ? CMD_REMOVE : r < 90 ? CMD_MATCH
                      : CMD_REDUCE);
        // Mostly small well-formed orders so matches walk several entries
        if ($urandom_range(0, 9) < 8)
        begin
            q.order_size = $urandom_range(0, 400);
            q.already_filled = $urandom_range(0, q.order_size);
            q.volume = $urandom_range(0, 1200);
        end
        if ($urandom_range(0, 3) != 0) q.owner_id = q.order_id[7:0];
        if (q.command == CMD_REMOVE && used_ids.size() > 0 && $urandom_range(0, 3) != 0)
        begin
            q.order_id = used_ids[$urandom_range(0, used_ids.size() - 1)];
            if ($urandom_range(0, 3) != 0) q.owner_id = q.order_id[7:0];
        end
        if (q.command == CMD_PUT)
        begin
            if (used_ids.size() > 0 && $urandom_range(0, 9) == 0)
                q.order_id = used_ids[$urandom_range(0, used_ids.size() - 1)];
            else
                q.order_id = $urandom_range(0, 199);
            q.owner_id = ($urandom_range(0, 3) != 0) ? q.order_id[7:0] : q.owner_id;
            used_ids.insert(used_ids.size(), q.order_id);
        end
        return q;
    endfunction

    // Start stays high after the accepting edge; busy holds off a second take
    task automatic send_request(input req_t q);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) gap = 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        request <= q;
        do @(posedge clk); while (busy);
        predict_level(q);
    endtask

    task automatic add_row(input req_t q, input logic pin, input kind_t k);
        row_t r;
        r.req = q; r.pin = pin; r.check_kind = k;
        plan.insert(plan.size(), r);
    endtask

    initial
    begin
        req_t q;
        for (int s = 0; s < DEPTH; s++) held[s] = 1'b0;
        head_q = 0; tail_q = 0; depth_q = 0; level_q = 0;

        // Directed table
        q = blank_req(CMD_MATCH); q.volume = VOL_MAX;
        add_row(q, 1, KIND_SUMMARY);
        q = blank_req(CMD_REMOVE);
        add_row(q, 1, KIND_REM_NF);
        q = blank_req(CMD_REDUCE); q.volume = VOL_MAX;
        add_row(q, 1, KIND_REDUCED);
        q = blank_req(CMD_PUT); q.order_size = 5; q.already_filled = 6;
        add_row(q, 1, KIND_PUT_REJ);
        q = blank_req(CMD_PUT); q.order_id = '1; q.owner_id = '1;
        q.order_size = '1; q.already_filled = 0; q.is_ask = 1; q.maker_reserve_price = '1;
        add_row(q, 1, KIND_PUT_OK);
        add_row(q, 1, KIND_PUT_REJ);
        q.owner_id = 0;
        q.command = CMD_REMOVE;
        add_row(q, 1, KIND_REM_NF);
        q = blank_req(CMD_PUT); q.order_id = 0; q.owner_id = 0; q.order_size = 7;
        q.already_filled = 7; q.is_ask = 0; q.maker_reserve_price = 0;
        add_row(q, 1, KIND_PUT_OK);
        q = blank_req(CMD_PUT); q.order_id = 3; q.order_size = 10; q.already_filled = 2;
        q.is_ask = 0;
        add_row(q, 0, KIND_PUT_OK);
        q = blank_req(CMD_MATCH); q.volume = 0;
        add_row(q, 1, KIND_SUMMARY);
        q = blank_req(CMD_MATCH); q.volume = 37'h0FFFFFFFF; q.taker_reserve_price = '1;
        add_row(q, 0, KIND_TRADE);
        q = blank_req(CMD_REDUCE); q.volume = 3;
        add_row(q, 1, KIND_REDUCED);
        q = blank_req(CMD_MATCH); q.volume = VOL_MAX; q.taker_reserve_price = 0;
        add_row(q, 0, KIND_TRADE);
        // Fill the level to the brim, then overflow it
        for (int i = 0; i < DEPTH + 1; i++)
        begin
            q = blank_req(CMD_PUT); q.order_id = 1000 + i; q.already_filled = 0;
            q.order_size = '1;
            add_row(q, 1, i < DEPTH ? KIND_PUT_OK : KIND_PUT_REJ);
        end
        q = blank_req(CMD_MATCH); q.volume = VOL_MAX;
        add_row(q, 0, KIND_TRADE);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            send_request(plan[i].req);
            if (plan[i].pin)
            begin
                // Pinned rows give one result, the newest one queued
                if (pending_results[pending_results.size() - 1].kind
                    !== plan[i].check_kind)
                begin
                    $display("%0t: table row %0d expected %p actual %p", $time, i,
                             plan[i].check_kind,
                             pending_results[pending_results.size() - 1].kind);
                    errors++;
                end
            end
        end

        for (int n = 0; n < 185; n++)
        begin
            if (n == 90)
            begin
                start <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0) @(posedge clk);
            end
            send_request(pick_req());
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
